FILE: rtl/facp_pkg.sv
// ----------------------------------------------------------------------------
// facp_pkg
// Shared types and constants of the framed ASCII command parser.
// ----------------------------------------------------------------------------
package facp_pkg;

  // Character codes used by the frame syntax.
  localparam logic [7:0] CHAR_SOF  = 8'h23;  // '#'
  localparam logic [7:0] CHAR_EOF  = 8'h0D;  // carriage return
  localparam logic [7:0] CHAR_L    = 8'h4C;
  localparam logic [7:0] CHAR_B    = 8'h42;
  localparam logic [7:0] CHAR_T    = 8'h54;
  localparam logic [7:0] CHAR_F    = 8'h46;
  localparam logic [7:0] CHAR_S    = 8'h53;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_1    = 8'h31;
  localparam logic [7:0] CHAR_4    = 8'h34;
  localparam logic [7:0] CHAR_9    = 8'h39;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd2;
  localparam logic [1:0] STATUS_FORMAT  = 2'd3;

  // Command kinds reported with each result.
  localparam logic [2:0] KIND_NONE       = 3'd0;
  localparam logic [2:0] KIND_LED_PERIOD = 3'd1;
  localparam logic [2:0] KIND_BTN_PERIOD = 3'd2;
  localparam logic [2:0] KIND_TMP_PERIOD = 3'd3;
  localparam logic [2:0] KIND_LED_SET    = 3'd4;
  localparam logic [2:0] KIND_BTN_READ   = 3'd5;
  localparam logic [2:0] KIND_TEMP_READ  = 3'd6;

  // Period divider: quotient of PERIOD_SCALE over the frequency.
  localparam int unsigned DIV_BITS     = 10;
  localparam logic [9:0]  PERIOD_SCALE = 10'd1000;

  typedef struct packed {
    logic [7:0] rx_char;
    logic [3:0] button_states;
    logic [7:0] temperature;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] command_kind;
    logic [2:0] target_index;
    logic [9:0] reported_value;
    logic [9:0] new_period;
    logic [3:0] led_states;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;      // an input item is taken this cycle
    logic latch_eval;  // register the frame evaluation
    logic div_start;   // launch the period division
    logic emit;        // load the result register and clear the frame
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_eof;    // the offered character ends a frame
    logic need_div;  // the frame is a valid frequency command
    logic div_done;  // the divider finishes this cycle
    logic out_free;  // the result register can take a new item
  } dp_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_EMIT
  } ctrl_state_e;

endpackage

FILE: rtl/facp_divider.sv
// ----------------------------------------------------------------------------
// facp_divider
// Restoring divider that computes PERIOD_SCALE / divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module facp_divider (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [9:0] divisor_i,
  output logic       done_o,
  output logic [9:0] quotient_o
);
  import facp_pkg::*;

  localparam int unsigned CW = $clog2(DIV_BITS + 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [10:0]   rem_q;
  logic [9:0]    quo_q;
  logic [9:0]    dvs_q;
  logic [10:0]   rem_sh;
  logic [10:0]   rem_nx;
  logic          fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    rem_sh = {rem_q[9:0], quo_q[9]};
    fits   = rem_sh >= {1'b0, dvs_q};
    rem_nx = fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
  end

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(DIV_BITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Remainder and quotient; the dividend shifts out as quotient bits shift in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= PERIOD_SCALE;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_nx;
      quo_q <= {quo_q[8:0], fits};
    end
  end

  assign done_o     = busy_q && (cnt_q == CW'(1));
  assign quotient_o = quo_q;

endmodule

FILE: rtl/facp_datapath.sv
// ----------------------------------------------------------------------------
// facp_datapath
// Frame capture, command decode, period divider and result register.
// ----------------------------------------------------------------------------
module facp_datapath #(
  parameter int unsigned FRAME_MAX = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  facp_pkg::ctrl_cmd_t   cmd_i,
  output facp_pkg::dp_status_t  status_o,
  input  facp_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output facp_pkg::out_item_t   out_data_o
);
  import facp_pkg::*;

  localparam int unsigned LW = $clog2(FRAME_MAX + 1);

  // Frame state: length, first '#' position and the bytes that follow it.
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] sof_q, sof_d;
  logic          sof_found_q, sof_found_d;
  logic          ovf_q, ovf_d;
  logic [7:0]    cap_q [5];
  logic [7:0]    cap_d [5];
  logic [LW-1:0] off;

  // Sensor values that came with the last item.
  logic [3:0] btn_q;
  logic [7:0] temp_q;

  // Stored LED values.
  logic [3:0] led_q, led_d;

  // Evaluation results.
  logic [1:0] ev_status_d, ev_status_q;
  logic [2:0] ev_kind_d, ev_kind_q;
  logic [2:0] ev_target_d, ev_target_q;
  logic [9:0] ev_value_d, ev_value_q;
  logic       ev_freq_d, ev_freq_q;

  logic [LW-1:0] rel;
  logic [1:0]    ndig;
  logic [1:0]    x;
  logic [9:0]    freq;
  logic          digits_ok;

  logic       out_valid_q;
  out_item_t  out_q;

  logic       div_done;
  logic [9:0] quotient;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CHAR_0) && (c <= CHAR_9);
  endfunction

  function automatic logic [9:0] dval(input logic [7:0] c);
    dval = {6'd0, c[3:0]};
  endfunction

  // Capture of an accepted character into the frame.
  always_comb begin
    len_d       = len_q;
    sof_d       = sof_q;
    sof_found_d = sof_found_q;
    ovf_d       = ovf_q;
    cap_d       = cap_q;
    off         = len_q - sof_q;
    if (cmd_i.emit) begin
      len_d       = '0;
      sof_d       = '0;
      sof_found_d = 1'b0;
      ovf_d       = 1'b0;
      for (int k = 0; k < 5; k++) begin
        cap_d[k] = '0;
      end
    end else if (cmd_i.accept) begin
      if (len_q < LW'(FRAME_MAX)) begin
        len_d = len_q + LW'(1);
        if (!sof_found_q) begin
          if (in_data_i.rx_char == CHAR_SOF) begin
            sof_found_d = 1'b1;
            sof_d       = len_q;
          end
        end else begin
          for (int k = 0; k < 5; k++) begin
            if (off == LW'(k + 1)) begin
              cap_d[k] = in_data_i.rx_char;
            end
          end
        end
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      sof_q       <= '0;
      sof_found_q <= 1'b0;
      ovf_q       <= 1'b0;
      for (int k = 0; k < 5; k++) begin
        cap_q[k] <= '0;
      end
    end else begin
      len_q       <= len_d;
      sof_q       <= sof_d;
      sof_found_q <= sof_found_d;
      ovf_q       <= ovf_d;
      cap_q       <= cap_d;
    end
  end

  // Sensor snapshot; only the one taken with the end character matters.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      btn_q  <= in_data_i.button_states;
      temp_q <= in_data_i.temperature;
    end
  end

  // Frequency digits, one to three of them after the command letters.
  always_comb begin
    rel       = len_q - sof_q;
    ndig      = 2'(rel - LW'(4));
    freq      = '0;
    digits_ok = 1'b0;
    case (ndig)
      2'd1: begin
        freq      = dval(cap_q[2]);
        digits_ok = is_digit(cap_q[2]);
      end
      2'd2: begin
        freq      = dval(cap_q[2]) * 10'd10 + dval(cap_q[3]);
        digits_ok = is_digit(cap_q[2]) && is_digit(cap_q[3]);
      end
      2'd3: begin
        freq      = dval(cap_q[2]) * 10'd100 + dval(cap_q[3]) * 10'd10 + dval(cap_q[4]);
        digits_ok = is_digit(cap_q[2]) && is_digit(cap_q[3]) && is_digit(cap_q[4]);
      end
      default: begin
        freq      = '0;
        digits_ok = 1'b0;
      end
    endcase
  end

  // Command decode, in order of precedence.
  always_comb begin
    ev_status_d = STATUS_OK;
    ev_kind_d   = KIND_NONE;
    ev_target_d = '0;
    ev_value_d  = '0;
    ev_freq_d   = 1'b0;
    led_d       = led_q;
    x           = 2'(cap_q[1] - CHAR_1);
    if (ovf_q || !sof_found_q) begin
      ev_status_d = STATUS_FORMAT;
    end else if ((cap_q[0] inside {CHAR_L, CHAR_B, CHAR_T}) && (cap_q[1] == CHAR_F)) begin
      if ((rel < LW'(4)) || (rel > LW'(7)) || !digits_ok || (freq == '0)) begin
        ev_status_d = STATUS_FORMAT;
      end else begin
        ev_freq_d  = 1'b1;
        ev_value_d = freq;
        if (cap_q[0] == CHAR_L) begin
          ev_kind_d = KIND_LED_PERIOD;
        end else if (cap_q[0] == CHAR_B) begin
          ev_kind_d = KIND_BTN_PERIOD;
        end else begin
          ev_kind_d = KIND_TMP_PERIOD;
        end
      end
    end else if ((cap_q[0] == CHAR_L) && (cap_q[2] == CHAR_S)) begin
      if (!(cap_q[1] inside {[CHAR_1:CHAR_4]}) || !(cap_q[3] inside {[CHAR_0:CHAR_1]})) begin
        ev_status_d = STATUS_FORMAT;
      end else begin
        led_d[x]    = (cap_q[3] == CHAR_1);
        ev_kind_d   = KIND_LED_SET;
        ev_target_d = {1'b0, x} + 3'd1;
        ev_value_d  = {9'd0, cap_q[3] == CHAR_1};
      end
    end else if ((cap_q[0] == CHAR_B) && (rel == LW'(4))) begin
      if (!(cap_q[1] inside {[CHAR_1:CHAR_4]})) begin
        ev_status_d = STATUS_FORMAT;
      end else begin
        ev_kind_d   = KIND_BTN_READ;
        ev_target_d = {1'b0, x} + 3'd1;
        ev_value_d  = {9'd0, btn_q[x]};
      end
    end else if (cap_q[0] == CHAR_T) begin
      ev_kind_d  = KIND_TEMP_READ;
      ev_value_d = {2'd0, temp_q};
    end else begin
      ev_status_d = STATUS_INVALID;
    end
  end

  // LED values change when a frame is evaluated.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q <= '0;
    end else if (cmd_i.latch_eval) begin
      led_q <= led_d;
    end
  end

  // Evaluation result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_eval) begin
      ev_status_q <= ev_status_d;
      ev_kind_q   <= ev_kind_d;
      ev_target_q <= ev_target_d;
      ev_value_q  <= ev_value_d;
      ev_freq_q   <= ev_freq_d;
    end
  end

  facp_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .divisor_i  (freq),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.status         <= ev_status_q;
      out_q.command_kind   <= ev_kind_q;
      out_q.target_index   <= ev_target_q;
      out_q.reported_value <= ev_value_q;
      out_q.new_period     <= ev_freq_q ? quotient : 10'd0;
      out_q.led_states     <= led_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status back to the controller.
  assign status_o.is_eof   = (in_data_i.rx_char == CHAR_EOF);
  assign status_o.need_div = ev_freq_d;
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

endmodule

FILE: rtl/facp_ctrl.sv
// ----------------------------------------------------------------------------
// facp_ctrl
// Sequencer: collects characters, then evaluates, divides if needed and emits a result.
module facp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  facp_pkg::dp_status_t  status_i,
  output facp_pkg::ctrl_cmd_t   cmd_o
);
  import facp_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d          = state_q;
    cmd_o.accept     = 1'b0;
    cmd_o.latch_eval = 1'b0;
    cmd_o.div_start  = 1'b0;
    cmd_o.emit       = 1'b0;
    in_stall_o       = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.is_eof) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.latch_eval = 1'b1;
        if (status_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/framed_ascii_command_parser_top.sv
// ----------------------------------------------------------------------------
// framed_ascii_command_parser_top
// Collects received characters into a frame and decodes one command per frame.
// ----------------------------------------------------------------------------
// Character items are taken as they arrive while a frame is collected. A
// carriage return closes the frame: the block then stalls its input while it
// evaluates the frame, runs the bit-serial period divider for frequency
// commands and loads the result register, and also while the previous result
// still waits to be taken. Only the bytes right after the first '#' are
// kept, so no clearing pass is needed.
module framed_ascii_command_parser_top #(
  parameter int unsigned FRAME_MAX = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  facp_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output facp_pkg::out_item_t  out_data_o
);
  import facp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  facp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  facp_datapath #(
    .FRAME_MAX (FRAME_MAX)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
